// File: rtl/ctsc_pkg.sv
// Package for the cosine Taylor series core: fixed-point constants and widths.
// Used by ctsc_div_cell and cosine_taylor_series_core; depends on nothing.
package ctsc_pkg;

   localparam int ANGLE_W    = 32;
   localparam int COS_W      = 32;
   localparam int TERM_W     = 56;   // magnitude of one series term, Q.48
   localparam int X2_W       = 54;   // reduced angle squared, Q.48
   localparam int TLO_W      = 28;
   localparam int XLO_W      = 27;
   localparam int PP_W       = TLO_W + XLO_W;
   localparam int ACC_W      = TERM_W + X2_W;
   localparam int FRAC_W     = 48;
   localparam int SUM_W      = 64;
   localparam int DVD_W      = 64;   // dividend into the divider chain
   localparam int CELL_BITS  = 8;    // quotient bits retired per cell
   localparam int CELL_COUNT = DVD_W / CELL_BITS;
   localparam int OUT_SHIFT  = 18;

   localparam logic signed [ANGLE_W-1:0] TWO_PI_Q24 = 32'sd105414357;
   localparam logic signed [ANGLE_W-1:0] PI_Q24     = 32'sd52707179;
   localparam logic signed [COS_W-1:0]   ONE_Q30    = 32'sd1073741824;

   // partial product selectors: term half x square half
   typedef enum logic [1:0] {
      PP_LL = 2'd0,
      PP_LH = 2'd1,
      PP_HL = 2'd2,
      PP_HH = 2'd3
   } pp_sel_type;

endpackage

// File: rtl/ctsc_div_cell.sv
// One cell of the restoring divider chain: retires CELL_BITS quotient bits per cycle.
// Depends on ctsc_pkg.
module ctsc_div_cell #(
   parameter int DW = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     vld_i,
   input  logic [ctsc_pkg::DVD_W-1:0] dvd_i,
   input  logic [ctsc_pkg::DVD_W-1:0] quo_i,
   input  logic [DW-1:0]            rem_i,
   input  logic [DW-1:0]            div_i,
   output logic                     vld_o,
   output logic [ctsc_pkg::DVD_W-1:0] dvd_o,
   output logic [ctsc_pkg::DVD_W-1:0] quo_o,
   output logic [DW-1:0]            rem_o
);
   import ctsc_pkg::*;

   logic                 vld_ff;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DW-1:0]        rem_ff, rem_in;

   always_comb begin
      logic [DW:0] trial;
      logic [DW-1:0] r;
      logic [DVD_W-1:0] d;
      logic [DVD_W-1:0] q;
      r = rem_i;
      d = dvd_i;
      q = quo_i;
      for (int i = 0; i < CELL_BITS; i++) begin
         trial = {r, d[DVD_W-1]};
         d = {d[DVD_W-2:0], 1'b0};
         if (trial >= {1'b0, div_i}) begin
            trial = trial - {1'b0, div_i};
            q = {q[DVD_W-2:0], 1'b1};
         end else begin
            q = {q[DVD_W-2:0], 1'b0};
         end
         r = trial[DW-1:0];
      end
      rem_in = r;
      dvd_in = d;
      quo_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_i;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign vld_o = vld_ff;
   assign dvd_o = dvd_ff;
   assign quo_o = quo_ff;
   assign rem_o = rem_ff;

endmodule

// File: rtl/cosine_taylor_series_core.sv
// Top level of the cosine Taylor series core: control, multiplier and divider chain.
// Depends on ctsc_pkg and ctsc_div_cell.
//
//   channel | ports                          | direction | payload
//   req     | req_valid, req_stall, req_angle | in        | angle, signed Q8.24 radians
//   rsp     | rsp_valid, rsp_stall, rsp_cosine | out      | cosine, signed Q2.30
//
// One item at a time. Range reduction takes one 2*pi step at a time (up to 20 steps), then
// a final check; each of the TERMS series terms builds the term x square product from four
// partial products on one multiplier, loads the divider chain and runs it through its
// CELL_COUNT (8) cells. Around these come the accept, square, final scale and hand-off
// steps; a zero, full-turn or half-turn angle skips the series.
// Reset is synchronous and clears the sequencer and the result valid.
// The result is copied into an output register; the next item is taken while it waits on
// rsp_stall, and a finished item holds in ST_DONE until the output register is free.
module cosine_taylor_series_core #(
   parameter int TERMS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ctsc_pkg::ANGLE_W-1:0] req_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ctsc_pkg::COS_W-1:0]   rsp_cosine
);
   import ctsc_pkg::*;

   localparam int KW = $clog2(TERMS + 1);
   localparam int DW = $clog2(2 * TERMS * (2 * TERMS - 1) + 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_REDUCE = 8'b0000_0010,
      ST_SQUARE = 8'b0000_0100,
      ST_MUL    = 8'b0000_1000,
      ST_DIVGO  = 8'b0001_0000,
      ST_DIVWT  = 8'b0010_0000,
      ST_FINAL  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [ANGLE_W-1:0]   x_ff, x_in;
   logic [X2_W-1:0]             x2_ff, x2_in;
   logic [TERM_W-1:0]           term_ff, term_in;
   logic                        tneg_ff, tneg_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [KW-1:0]               k_ff, k_in;
   logic [DW-1:0]               d_ff, d_in;
   logic [2:0]                  pcnt_ff, pcnt_in;
   logic [PP_W-1:0]             pp_ff, pp_in;
   pp_sel_type                  psel_ff, psel_in;
   logic                        ppv_ff, ppv_in;
   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic signed [COS_W-1:0]     res_ff, res_in;
   logic signed [COS_W-1:0]     cos_ff, cos_in;
   logic                        rv_ff, rv_in;

   // divider chain taps
   logic [CELL_COUNT:0]         cv;
   logic [DVD_W-1:0]            cdvd [CELL_COUNT+1];
   logic [DVD_W-1:0]            cquo [CELL_COUNT+1];
   logic [DW-1:0]               crem [CELL_COUNT+1];

   // (2k-1)*2k for the next term index
   function automatic logic [DW-1:0] div_of(input logic [KW-1:0] k);
      logic [KW:0]       k2;
      logic [2*KW+1:0]   p;
      k2 = {k, 1'b0};
      p  = {{(KW+1){1'b0}}, k2 - {{KW{1'b0}}, 1'b1}} * {{(KW+1){1'b0}}, k2};
      return p[DW-1:0];
   endfunction

   // feed the chain: floor of |term|*x2 / 2^48, rounded up when the term is negative
   assign cv[0]   = (state_ff == ST_DIVGO);
   assign cdvd[0] = {{(DVD_W-(ACC_W-FRAC_W)){1'b0}}, acc_ff[ACC_W-1:FRAC_W]}
                    + {{(DVD_W-1){1'b0}}, (tneg_ff && (acc_ff[FRAC_W-1:0] != '0))};
   assign cquo[0] = '0;
   assign crem[0] = '0;

   for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
      ctsc_div_cell #(.DW(DW)) u_cell (
         .clock (clock),
         .reset (reset),
         .vld_i (cv[g]),
         .dvd_i (cdvd[g]),
         .quo_i (cquo[g]),
         .rem_i (crem[g]),
         .div_i (d_ff),
         .vld_o (cv[g+1]),
         .dvd_o (cdvd[g+1]),
         .quo_o (cquo[g+1]),
         .rem_o (crem[g+1])
      );
   end

   always_comb begin
      logic signed [TLO_W-1:0]   xs;
      logic signed [2*TLO_W-1:0] sq;
      logic [TLO_W-1:0]          ma;
      logic [XLO_W-1:0]          mb;
      logic [ACC_W-1:0]          addend;
      logic [TERM_W-1:0]         mag;
      logic signed [SUM_W-1:0]   tval;
      logic signed [SUM_W-1:0]   r;
      logic                      out_free;

      state_in = state_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      term_in  = term_ff;
      tneg_in  = tneg_ff;
      sum_in   = sum_ff;
      k_in     = k_ff;
      d_in     = d_ff;
      pcnt_in  = pcnt_ff;
      pp_in    = pp_ff;
      psel_in  = psel_ff;
      ppv_in   = 1'b0;
      acc_in   = acc_ff;
      res_in   = res_ff;
      cos_in   = cos_ff;
      rv_in    = rv_ff && rsp_stall;
      out_free = !rv_ff || !rsp_stall;

      xs     = x_ff[TLO_W-1:0];
      sq     = xs * xs;
      ma     = '0;
      mb     = '0;
      addend = '0;
      mag    = cquo[CELL_COUNT][TERM_W-1:0];
      tval   = '0;
      r      = sum_ff >>> OUT_SHIFT;

      // accumulate the partial product registered in the previous cycle
      if (ppv_ff) begin
         case (psel_ff)
            PP_LL:   addend = {{(ACC_W-PP_W){1'b0}}, pp_ff};
            PP_LH:   addend = {{(ACC_W-PP_W){1'b0}}, pp_ff} << XLO_W;
            PP_HL:   addend = {{(ACC_W-PP_W){1'b0}}, pp_ff} << TLO_W;
            default: addend = {{(ACC_W-PP_W){1'b0}}, pp_ff} << PP_W;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_angle;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (x_ff > TWO_PI_Q24) begin
               x_in = x_ff - TWO_PI_Q24;
            end else if (x_ff < -TWO_PI_Q24) begin
               x_in = x_ff + TWO_PI_Q24;
            end else if (x_ff == '0 || x_ff == TWO_PI_Q24 || x_ff == -TWO_PI_Q24) begin
               res_in   = ONE_Q30;
               state_in = ST_DONE;
            end else if (x_ff == PI_Q24 || x_ff == -PI_Q24) begin
               res_in   = -ONE_Q30;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            x2_in    = sq[X2_W-1:0];
            term_in  = TERM_W'(1) << FRAC_W;
            tneg_in  = 1'b0;
            sum_in   = SUM_W'(1) << FRAC_W;
            k_in     = KW'(1);
            d_in     = div_of(KW'(1));
            pcnt_in  = '0;
            acc_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_in = acc_ff + addend;
            if (pcnt_ff == 3'd4) begin
               state_in = ST_DIVGO;
            end else begin
               ma      = pcnt_ff[1] ? term_ff[TERM_W-1:TLO_W] : term_ff[TLO_W-1:0];
               mb      = pcnt_ff[0] ? x2_ff[X2_W-1:XLO_W] : x2_ff[XLO_W-1:0];
               pp_in   = {{XLO_W{1'b0}}, ma} * {{TLO_W{1'b0}}, mb};
               psel_in = pp_sel_type'(pcnt_ff[1:0]);
               ppv_in  = 1'b1;
               pcnt_in = pcnt_ff + 3'd1;
            end
         end
         ST_DIVGO: begin
            state_in = ST_DIVWT;
         end
         ST_DIVWT: begin
            if (cv[CELL_COUNT]) begin
               // new term takes the opposite sign; division truncates toward zero
               tval    = {{(SUM_W-TERM_W){1'b0}}, mag};
               sum_in  = tneg_ff ? sum_ff + tval : sum_ff - tval;
               term_in = mag;
               tneg_in = !tneg_ff;
               if (k_ff == KW'(TERMS)) begin
                  state_in = ST_FINAL;
               end else begin
                  k_in     = k_ff + KW'(1);
                  d_in     = div_of(k_ff + KW'(1));
                  pcnt_in  = '0;
                  acc_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_FINAL: begin
            // floor scale to Q2.30, then clamp to plus or minus one
            if (r > SUM_W'(ONE_Q30)) begin
               res_in = ONE_Q30;
            end else if (r < -SUM_W'(ONE_Q30)) begin
               res_in = -ONE_Q30;
            end else begin
               res_in = r[COS_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free, then hand the item over
            if (out_free) begin
               cos_in   = res_ff;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         ppv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         ppv_ff   <= ppv_in;
      end
      x_ff    <= x_in;
      x2_ff   <= x2_in;
      term_ff <= term_in;
      tneg_ff <= tneg_in;
      sum_ff  <= sum_in;
      k_ff    <= k_in;
      d_ff    <= d_in;
      pcnt_ff <= pcnt_in;
      pp_ff   <= pp_in;
      psel_ff <= psel_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      cos_ff  <= cos_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rv_ff;
   assign rsp_cosine = cos_ff;

endmodule

// File: sim/cosine_taylor_series_core_test.sv
// Testbench for cosine_taylor_series_core: directed and random angles, bit-exact cosine check.
// Depends on ctsc_pkg and the core RTL; self-contained otherwise.
module cosine_taylor_series_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ctsc_pkg::*;

   localparam int NUM_TERMS = 20;
   localparam longint TWO_PI = 105414357;
   localparam longint HALF_PI_TURN = 52707179;
   localparam longint UNITY = 1073741824;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [ANGLE_W-1:0] req_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [COS_W-1:0] rsp_cosine;

   logic signed [ANGLE_W-1:0] pending_angles[$];
   logic signed [COS_W-1:0] expected_cosines[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_sender = 1'b0;
   bit stim_done = 1'b0;
   int fail_count = 0;

   cosine_taylor_series_core #(.TERMS(NUM_TERMS)) DUT (.*);

   always #5 clock = ~clock;

   // floor(a*b / 2^48) on magnitudes, sign restored with rounding toward minus infinity
   function automatic longint scale_q48(longint a, longint b);
      bit neg;
      logic [127:0] prod;
      logic [63:0] q;
      begin
         neg = (a < 0) != (b < 0);
         prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
         q = prod[111:48];
         if (neg && prod[47:0] != 0) q = q + 1;
         q[63:62] = 2'b00;
         return neg ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic logic signed [COS_W-1:0] predict_cosine(logic signed [ANGLE_W-1:0] ang);
      longint x, x2, term, sum, res;
      begin
         x = ang;
         while (x > TWO_PI || x < -TWO_PI) x = (x > TWO_PI) ? x - TWO_PI : x + TWO_PI;
         if (x == 0 || x == TWO_PI || x == -TWO_PI) res = UNITY;
         else if (x == HALF_PI_TURN || x == -HALF_PI_TURN) res = -UNITY;
         else begin
            x2 = x * x;
            term = longint'(1) << 48;
            sum = term;
            for (int k = 1; k <= NUM_TERMS; k++) begin
               term = -(scale_q48(term, x2) / longint'((2*k-1)*(2*k)));
               sum += term;
            end
            // floor divide by 2^18
            res = sum >>> OUT_SHIFT;
            if (res > UNITY) res = UNITY;
            if (res < -UNITY) res = -UNITY;
         end
         return res[COS_W-1:0];
      end
   endfunction

   // Driver: hold payload while stalled, advance on accept, idle at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (req_valid) expected_cosines.push_back(predict_cosine(req_angle));
            if (pending_angles.size() > 0 && !hold_sender &&
                $urandom_range(99, 0) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_angle <= pending_angles.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted cosine with the oldest prediction; stall at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cosines.size() == 0) begin
               $display("%0t: cosine expected none actual %0d", $time, rsp_cosine);
               fail_count++;
            end else begin
               logic signed [COS_W-1:0] exp_cos;
               exp_cos = expected_cosines.pop_front();
               if (exp_cos !== rsp_cosine) begin
                  $display("%0t: cosine expected %0d actual %0d", $time, exp_cos, rsp_cosine);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   task automatic drain();
      while (pending_angles.size() > 0 || req_valid || expected_cosines.size() > 0)
         @(posedge clock);
   endtask

   function automatic logic signed [ANGLE_W-1:0] random_angle();
      case ($urandom_range(3, 0))
         0: return ANGLE_W'($urandom());
         1: return ANGLE_W'($signed($urandom_range(2 * TWO_PI, 0)) - TWO_PI);
         2: return ANGLE_W'(($urandom_range(1, 0) ? 1 : -1) * (HALF_PI_TURN
                   + $urandom_range(4, 0) - 2 + TWO_PI * $urandom_range(19, 0)));
         default: return ANGLE_W'($signed($urandom_range(400, 0)) - 200);
      endcase
   endfunction

   initial begin
      logic signed [ANGLE_W-1:0] directed[$];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      directed = '{32'sh7FFFFFFF, 32'sh80000000, 0, 1, -1, ANGLE_W'(TWO_PI),
                   ANGLE_W'(-TWO_PI), ANGLE_W'(TWO_PI + 1), ANGLE_W'(HALF_PI_TURN),
                   ANGLE_W'(-HALF_PI_TURN), ANGLE_W'(HALF_PI_TURN + 1),
                   ANGLE_W'(3 * HALF_PI_TURN), ANGLE_W'(2 * TWO_PI), ANGLE_W'(-5 * TWO_PI),
                   ANGLE_W'(20 * TWO_PI), 32'sh55555555, 32'shAAAAAAAA,
                   ANGLE_W'(HALF_PI_TURN / 2), ANGLE_W'(TWO_PI - 1)};
      foreach (directed[i]) pending_angles.push_back(directed[i]);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 80 : 0;
         recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 16 : 0;
         for (int i = 0; i < 250; i++) begin
            pending_angles.push_back(random_angle());
            // pause the sender once per phase until everything has come back
            if (i == 120) begin
               while (pending_angles.size() > 0 || req_valid) @(posedge clock);
               hold_sender = 1'b1;
               drain();
               hold_sender = 1'b0;
            end
         end
         drain();
      end
      repeat (400) @(posedge clock);
      if (fail_count == 0 && expected_cosines.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // 769 items, heavy stalls: well under this bound
   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// File: sim.f
rtl/ctsc_pkg.sv
rtl/ctsc_div_cell.sv
rtl/cosine_taylor_series_core.sv
sim/cosine_taylor_series_core_test.sv
